[sv/hrdlb_pkg.sv]
// Shared types, codes and constants of the leaky bucket checker.
package hrdlb_pkg;

  // Field widths
  localparam int BITS_W  = 29;
  localparam int IDEAL_W = 28;
  localparam int BYTES_W = 26;
  localparam int DELAY_W = 31;
  localparam int FLAGS_W = 5;
  localparam int MODE_W  = 2;
  localparam int ACC_W   = 33;
  localparam int CFG_ADDR_W = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BUFFER_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_FULL    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDEAL_FRAME  = 2'd2;

  // Register reset values
  localparam logic [BITS_W-1:0]  BUFFER_SIZE_RST = 29'd4096000;
  localparam logic [BITS_W-1:0]  INIT_FULL_RST   = 29'd3276800;
  localparam logic [IDEAL_W-1:0] IDEAL_FRAME_RST = 28'd0;

  // Status flag bit positions
  localparam int FLAG_TOO_BIG   = 0;
  localparam int FLAG_DEC_UNDER = 1;
  localparam int FLAG_DEC_OVER  = 2;
  localparam int FLAG_ENC_UNDER = 3;
  localparam int FLAG_ENC_OVER  = 4;

  typedef struct packed {
    logic [BITS_W-1:0]  buffer_size;
    logic [BITS_W-1:0]  init_full;
    logic [IDEAL_W-1:0] ideal_frame;
  } cfg_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]        flags;
    logic [BITS_W-1:0]         fullness;
    logic signed [DELAY_W-1:0] delay;
  } step_res_t;

  // Clamp a carry to plus or minus the buffer size
  function automatic logic signed [ACC_W-1:0] clamp_carry(
    input logic signed [ACC_W-1:0] c,
    input logic [BITS_W-1:0]       b
  );
    logic signed [ACC_W-1:0] bp;
    logic signed [ACC_W-1:0] bn;
    bp = $signed({{(ACC_W-BITS_W){1'b0}}, b});
    bn = -bp;
    if (c > bp) begin
      clamp_carry = bp;
    end else if (c < bn) begin
      clamp_carry = bn;
    end else begin
      clamp_carry = c;
    end
  endfunction

endpackage

[sv/hrd_leaky_bucket_checker_core.sv]
// Top level of the leaky bucket checker: input register, bucket state, result register.
//
// Usage:
//   s_axis carries one coded frame per transfer: tuser holds the mode
//   (check, commit, restart), tdata holds the frame size in bytes.
//   m_axis returns one result per input transfer, in order: status flags,
//   bucket fullness and signed delay carry, all in bits.
//   cfg_we/cfg_addr/cfg_wdata write the buffer size, initial fullness and
//   ideal bits per frame; write them only while no frame is in flight.
// Timing:
//   A frame taken from s_axis is held in the input register; its result is
//   computed combinationally and loaded into the result register when the
//   output is free. One frame per cycle is sustained while m_axis_tready
//   stays high; the bucket update is a single combinational pass,
//   so a commit is seen by the frame right behind it.
// Reset: clears both pipeline registers, zeroes fullness and carry, and
//   loads the register defaults.
// Stall: while m_axis_tready is low the result holds and the input register
//   holds its frame; s_axis_tready drops once the input register is full.
module hrd_leaky_bucket_checker_core
  import hrdlb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [25:0] frame_bytes
  input  logic [1:0]            s_axis_tuser,   // [1:0] mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // [4:0] status_flags, [33:5] fullness_bits,
                                                // [64:34] delay_bits
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BITS_W-1:0]     cfg_wdata
);

  cfg_t                      cfg;
  logic                      in_valid;
  logic [MODE_W-1:0]         in_mode;
  logic [BYTES_W-1:0]        in_bytes;
  logic                      advance;
  logic                      out_free;
  logic [BITS_W-1:0]         fullness;
  logic signed [DELAY_W-1:0] carry;
  step_res_t                 res;
  step_res_t                 out_res;

  hrdlb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hrdlb_step u_step (
    .cfg         (cfg),
    .mode        (in_mode),
    .frame_bytes (in_bytes),
    .fullness    (fullness),
    .carry       (carry),
    .res         (res)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Capture an incoming frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode  <= s_axis_tuser;
      in_bytes <= s_axis_tdata[BYTES_W-1:0];
    end
  end

  // Update the bucket on commit and restart
  always_ff @(posedge clk) begin
    if (rst) begin
      fullness <= '0;
      carry    <= '0;
    end else if (advance && (in_mode == MODE_COMMIT || in_mode == MODE_RESTART)) begin
      fullness <= res.fullness;
      carry    <= res.delay;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {7'd0, out_res.delay, out_res.fullness, out_res.flags};

`ifndef SYNTHESIS
  // A check leaves the bucket as it was
  a_check_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && in_mode == MODE_CHECK) |=> ($stable(fullness) && $stable(carry)))
    else $error("check mode changed bucket state");

  // A restart loads the saturated initial fullness and clears the carry
  a_restart_load: assert property (@(posedge clk) disable iff (rst)
    (advance && in_mode == MODE_RESTART) |=>
      (fullness == $past(res.fullness) && carry == '0 && out_res.flags == '0))
    else $error("restart did not reload the bucket");

  // A new result appears only when a frame moves out of the input register
  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(m_axis_tvalid)) |-> $past(advance))
    else $error("result valid without a frame");

  // A held frame stays in the input register while the output is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_mode) && $stable(in_bytes)))
    else $error("input register lost a frame");

  // The unused mode reports no flags and leaves the bucket alone
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && in_mode == MODE_NONE) |=>
      (out_res.flags == '0 && $stable(fullness) && $stable(carry)))
    else $error("unused mode acted");
`endif

endmodule

[sv/hrdlb_cfg_regs.sv]
// Configuration register file of the leaky bucket checker.
module hrdlb_cfg_regs
  import hrdlb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BITS_W-1:0]     cfg_wdata,
  output cfg_t                  cfg
);

  // Write one register per enabled cycle; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_size <= BUFFER_SIZE_RST;
      cfg.init_full   <= INIT_FULL_RST;
      cfg.ideal_frame <= IDEAL_FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BUFFER_SIZE: cfg.buffer_size <= cfg_wdata;
        CFG_INIT_FULL:   cfg.init_full   <= cfg_wdata;
        CFG_IDEAL_FRAME: cfg.ideal_frame <= cfg_wdata[IDEAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/hrdlb_step.sv]
// Bucket update for one frame: removal phase, add phase and mode select.
module hrdlb_step
  import hrdlb_pkg::*;
(
  input  cfg_t                      cfg,
  input  logic [MODE_W-1:0]         mode,
  input  logic [BYTES_W-1:0]        frame_bytes,
  input  logic [BITS_W-1:0]         fullness,
  input  logic signed [DELAY_W-1:0] carry,
  output step_res_t                 res
);

  logic [BITS_W-1:0]       fb;
  logic signed [ACC_W-1:0] b_s;
  logic signed [ACC_W-1:0] fb_s;
  logic signed [ACC_W-1:0] f0;
  logic signed [ACC_W-1:0] c0;
  logic signed [ACC_W-1:0] t1;
  logic signed [ACC_W-1:0] d1;
  logic signed [ACC_W-1:0] f1;
  logic signed [ACC_W-1:0] c1;
  logic signed [ACC_W-1:0] t2;
  logic signed [ACC_W-1:0] f2;
  logic signed [ACC_W-1:0] c2;
  logic [FLAGS_W-1:0]      fl;
  logic [BITS_W-1:0]       restart_full;

  assign fb   = {frame_bytes, 3'b000};
  assign b_s  = $signed({{(ACC_W-BITS_W){1'b0}}, cfg.buffer_size});
  assign fb_s = $signed({{(ACC_W-BITS_W){1'b0}}, fb});
  assign f0   = $signed({{(ACC_W-BITS_W){1'b0}}, fullness});
  assign c0   = {{(ACC_W-DELAY_W){carry[DELAY_W-1]}}, carry};
  assign t1   = f0 + c0;
  assign d1   = t1 - fb_s;

  // Removal phase: take the frame's bits out unless the frame is too big
  always_comb begin
    fl = '0;
    f1 = f0;
    c1 = c0;
    if (fb > cfg.buffer_size) begin
      fl[FLAG_TOO_BIG] = 1'b1;
    end else begin
      if (fb_s > t1) begin
        fl[FLAG_DEC_UNDER] = 1'b1;
        c1 = clamp_carry(d1, cfg.buffer_size);
        f1 = '0;
      end else if (d1 < b_s) begin
        f1 = d1;
        c1 = '0;
      end else begin
        fl[FLAG_DEC_OVER] = 1'b1;
        c1 = clamp_carry(d1 - b_s, cfg.buffer_size);
        f1 = b_s;
      end
    end
  end

  assign t2 = f1 + $signed({{(ACC_W-IDEAL_W){1'b0}}, cfg.ideal_frame}) + c1;

  // Add phase: top up with the ideal frame bits and clamp
  always_comb begin
    f2 = '0;
    c2 = '0;
    if (t2 <= b_s) begin
      if (t2 >= 0) begin
        f2 = t2;
      end else begin
        c2 = clamp_carry(t2, cfg.buffer_size);
      end
    end else begin
      f2 = b_s;
      c2 = clamp_carry(t2 - b_s, cfg.buffer_size);
    end
  end

  assign restart_full = (cfg.init_full > cfg.buffer_size) ? cfg.buffer_size : cfg.init_full;

  // Select the result by mode
  always_comb begin
    res.flags    = '0;
    res.fullness = fullness;
    res.delay    = carry;
    case (mode)
      MODE_CHECK, MODE_COMMIT: begin
        res.flags    = fl;
        if (t2 < 0) res.flags[FLAG_ENC_UNDER] = 1'b1;
        if (t2 > b_s) res.flags[FLAG_ENC_OVER] = 1'b1;
        res.fullness = f2[BITS_W-1:0];
        res.delay    = c2[DELAY_W-1:0];
      end
      MODE_RESTART: begin
        res.fullness = restart_full;
        res.delay    = '0;
      end
      default: ;
    endcase
  end

endmodule
